// ===== hw/rtl/crcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// crcdt_pkg
// Shared widths, operation codes and helpers for the CAN receive
// change-detect table.
// ----------------------------------------------------------------------------
package crcdt_pkg;

    localparam int IDX_W       = 6;
    localparam int ID_W        = 29;
    localparam int STD_W       = 11;
    localparam int LEN_W       = 4;
    localparam int DATA_W      = 64;
    localparam int OP_W        = 2;
    localparam int BYTES       = DATA_W / 8;
    localparam int ENTRIES_DEF = 64;
    localparam int ENTRIES_MAX = 256;
    // wide enough to hold any entry count up to ENTRIES_MAX
    localparam int CNT_W       = $clog2(ENTRIES_MAX + 1);

    typedef enum logic [OP_W-1:0] {
        OP_RX   = 2'd0,
        OP_LOAD = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_entry;

    // dlc above 8 counts as 8
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] dlc);
        logic [LEN_W-1:0] r;
        r = (dlc > LEN_W'(BYTES)) ? LEN_W'(BYTES) : dlc;
        return r;
    endfunction

    // ones in the first n bytes
    function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        logic [DATA_W-1:0] m;
        int                i;
        m = '0;
        for (i = 0; i < BYTES; i++) begin
            m[i*8 +: 8] = (LEN_W'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== hw/rtl/crcdt_if.sv =====
// ----------------------------------------------------------------------------
// crcdt_if
// Valid/ready channels: request items in, result items out.
// ----------------------------------------------------------------------------
interface crcdt_req_if;
    import crcdt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  filter_index;
    logic              is_remote;
    logic              is_extended;
    logic [STD_W-1:0]  std_id;
    logic [ID_W-1:0]   ext_id;
    logic [ID_W-1:0]   load_id;
    logic [LEN_W-1:0]  dlc;
    logic [DATA_W-1:0] payload;

    modport source (
        output valid, op, filter_index, is_remote, is_extended,
               std_id, ext_id, load_id, dlc, payload,
        input  ready
    );
    modport sink (
        input  valid, op, filter_index, is_remote, is_extended,
               std_id, ext_id, load_id, dlc, payload,
        output ready
    );
endinterface

interface crcdt_rsp_if;
    import crcdt_pkg::*;

    logic              valid;
    logic              ready;
    logic              updated;
    logic              read_valid;
    logic              pending;
    logic [IDX_W-1:0]  out_index;
    logic [ID_W-1:0]   out_id;
    logic [LEN_W-1:0]  out_len;
    logic [DATA_W-1:0] out_data;

    modport source (
        output valid, updated, read_valid, pending, out_index, out_id,
               out_len, out_data,
        input  ready
    );
    modport sink (
        input  valid, updated, read_valid, pending, out_index, out_id,
               out_len, out_data,
        output ready
    );
endinterface

// ===== hw/rtl/can_rx_change_detect_table.sv =====
// ----------------------------------------------------------------------------
// can_rx_change_detect_table
// Per-filter-index receive table with change detection and a single
// pending-change notice that a read op returns and clears.
// ----------------------------------------------------------------------------
//
//  channel  | dir | modport | carries
//  ---------+-----+---------+-----------------------------------------------
//  i_req    | in  | sink    | op, filter_index, frame fields, load_id
//  o_rsp    | out | source  | updated, read_valid, pending, returned entry
//
//  One transfer per cycle while o_rsp is not stalled; table read at the request
//  transfer, compare/write as the item moves from input stage to result reg.
//  A write followed at once by a read of the same entry is forwarded.
//  Reset clears the per-entry valid bits; invalid entries read
//  as zero, so no clearing pass is needed.
//  A stalled o_rsp holds the result; i_req still takes one more transfer
//  into the input stage before backpressure reaches it.
//
module can_rx_change_detect_table
    import crcdt_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    crcdt_req_if.sink        i_req,
    crcdt_rsp_if.source      o_rsp
);

    // table address width; at least one bit
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [CNT_W-1:0] ENTRIES_V = CNT_W'(ENTRIES);

    // ---------------- table storage ----------------
    t_entry               r_mem [ENTRIES];
    logic [ENTRIES-1:0]   r_vld;          // entry written since reset

    // ---------------- input stage ----------------
    logic                 r_s1_valid;
    t_op                  r_s1_op;
    logic [IDX_W-1:0]     r_s1_idx;
    logic                 r_s1_remote;
    logic [ID_W-1:0]      r_s1_fid;       // selected frame id
    logic [ID_W-1:0]      r_s1_lid;
    logic [LEN_W-1:0]     r_s1_len;       // saturated dlc
    logic [DATA_W-1:0]    r_s1_payload;
    t_entry               r_rd_ent;       // registered table read
    logic                 r_rd_vld;
    logic                 r_fwd;          // previous write hit same entry
    t_entry               r_fwd_ent;

    // ---------------- notice and shadow of the noticed entry ----------------
    logic                 r_nt_flag;
    logic [IDX_W-1:0]     r_nt_idx;
    t_entry               r_nt_ent;       // always equals table[r_nt_idx]

    // ---------------- result register ----------------
    logic                 r_out_valid;
    logic                 r_updated;
    logic                 r_read_valid;
    logic                 r_pending;
    logic [IDX_W-1:0]     r_out_index;
    t_entry               r_out_ent;

    // ---------------- combinational ----------------
    logic                 in_fire;
    logic                 s1_adv;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 idx_ok;
    t_entry               cur;
    logic [DATA_W-1:0]    mask;
    logic [DATA_W-1:0]    new_data;
    logic                 change;
    logic                 load_ok;
    logic                 s1_wr;
    t_entry               n_wr_ent;
    logic                 n_nt_flag;
    logic [IDX_W-1:0]     n_nt_idx;
    t_entry               n_nt_ent;
    logic                 n_updated;
    logic                 n_read_valid;
    logic [IDX_W-1:0]     n_out_index;
    t_entry               n_out_ent;

    // result reg frees when empty or taken; input stage advances into it
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_fire     = i_req.valid && i_req.ready;

    // filter_index widened then cut to the table address width
    assign rd_addr = AW'(CNT_W'(i_req.filter_index));
    assign wr_addr = AW'(CNT_W'(r_s1_idx));
    assign idx_ok  = CNT_W'(r_s1_idx) < ENTRIES_V;

    // entry as seen by this item: forwarded write, stored, or reset zero
    always_comb begin
        if (r_fwd) begin
            cur = r_fwd_ent;
        end else if (r_rd_vld) begin
            cur = r_rd_ent;
        end else begin
            cur = '0;
        end
    end

    assign mask     = byte_mask(r_s1_len);
    assign new_data = r_s1_payload & mask;

    // data frame, matching id, some byte compared and differing
    assign change = (r_s1_op == OP_RX) && !r_s1_remote && idx_ok
                 && (r_s1_fid == cur.id) && (r_s1_len != '0)
                 && (new_data != (cur.data & mask));
    assign load_ok = (r_s1_op == OP_LOAD) && idx_ok;
    assign s1_wr   = s1_adv && (change || load_ok);

    always_comb begin
        n_wr_ent     = '0;
        n_nt_flag    = r_nt_flag;
        n_nt_idx     = r_nt_idx;
        n_nt_ent     = r_nt_ent;
        n_updated    = 1'b0;
        n_read_valid = 1'b0;
        n_out_index  = '0;
        n_out_ent    = '0;
        unique case (r_s1_op)
            OP_RX: begin
                n_wr_ent = '{id: r_s1_fid, len: r_s1_len, data: new_data};
                if (change) begin
                    n_nt_flag = 1'b1;
                    n_nt_idx  = r_s1_idx;
                    n_nt_ent  = n_wr_ent;
                    n_updated = 1'b1;
                end
            end
            OP_LOAD: begin
                n_wr_ent = '{id: r_s1_lid, len: '0, data: '0};
                // keep the shadow in step with the noticed entry
                if (load_ok && (r_s1_idx == r_nt_idx)) begin
                    n_nt_ent = n_wr_ent;
                end
            end
            OP_READ: begin
                if (r_nt_flag) begin
                    n_read_valid = 1'b1;
                    n_out_index  = r_nt_idx;
                    n_out_ent    = r_nt_ent;
                    n_nt_flag    = 1'b0;
                end
            end
            default: begin
                // unused op code: no effect
            end
        endcase
    end

    // ---------------- table write and registered read ----------------
    always_ff @(posedge i_clk) begin
        if (s1_wr) begin
            r_mem[wr_addr] <= n_wr_ent;
        end
        if (in_fire) begin
            r_rd_ent  <= r_mem[rd_addr];
            r_fwd_ent <= n_wr_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (s1_wr) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (in_fire) begin
                r_rd_vld <= r_vld[rd_addr];
                r_fwd    <= s1_wr && (wr_addr == rd_addr);
            end
        end
    end

    // ---------------- input stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op      <= t_op'(i_req.op);
            r_s1_idx     <= i_req.filter_index;
            r_s1_remote  <= i_req.is_remote;
            r_s1_fid     <= i_req.is_extended ? i_req.ext_id
                                              : ID_W'(i_req.std_id);
            r_s1_lid     <= i_req.load_id;
            r_s1_len     <= sat_len(i_req.dlc);
            r_s1_payload <= i_req.payload;
        end
    end

    // ---------------- notice state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt_flag <= 1'b0;
            r_nt_idx  <= '0;
            r_nt_ent  <= '0;
        end else if (s1_adv) begin
            r_nt_flag <= n_nt_flag;
            r_nt_idx  <= n_nt_idx;
            r_nt_ent  <= n_nt_ent;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_updated    <= n_updated;
            r_read_valid <= n_read_valid;
            r_pending    <= n_nt_flag;
            r_out_index  <= n_out_index;
            r_out_ent    <= n_out_ent;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.updated    = r_updated;
    assign o_rsp.read_valid = r_read_valid;
    assign o_rsp.pending    = r_pending;
    assign o_rsp.out_index  = r_out_index;
    assign o_rsp.out_id     = r_out_ent.id;
    assign o_rsp.out_len    = r_out_ent.len;
    assign o_rsp.out_data   = r_out_ent.data;

endmodule

// ===== hw/rtl/crcdt_checker.sv =====
// ----------------------------------------------------------------------------
// crcdt_checker
// Port-level checks on the result channel of the change-detect table.
// ----------------------------------------------------------------------------
module crcdt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_updated,
    input logic                        i_read_valid,
    input logic                        i_pending,
    input logic [crcdt_pkg::IDX_W-1:0]  i_out_index,
    input logic [crcdt_pkg::ID_W-1:0]   i_out_id,
    input logic [crcdt_pkg::LEN_W-1:0]  i_out_len,
    input logic [crcdt_pkg::DATA_W-1:0] i_out_data
);
    import crcdt_pkg::*;

    // a step either changes an entry or returns one, never both
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_updated && i_read_valid))
        else $error("updated and read_valid both set");

    // a change always leaves the notice pending; a read clears it
    a_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_updated || i_read_valid) |-> (i_pending == i_updated))
        else $error("pending flag inconsistent with step");

    // no returned frame means all returned fields are zero
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_read_valid |->
            (i_out_index == '0) && (i_out_id == '0) && (i_out_len == '0)
            && (i_out_data == '0))
        else $error("returned fields not zero without a read");

    // stored length never exceeds eight bytes
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_len <= LEN_W'(BYTES)))
        else $error("returned length above eight");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_out_id) && $stable(i_pending))
        else $error("stalled result changed");

endmodule

bind can_rx_change_detect_table crcdt_checker u_crcdt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_updated    (o_rsp.updated),
    .i_read_valid (o_rsp.read_valid),
    .i_pending    (o_rsp.pending),
    .i_out_index  (o_rsp.out_index),
    .i_out_id     (o_rsp.out_id),
    .i_out_len    (o_rsp.out_len),
    .i_out_data   (o_rsp.out_data)
);
